// ===== hdl/ssrrip_pkg.sv =====
// Shared types and constants for the stream-aware SHiP/DRRIP replacement core.
// No dependencies.
`timescale 1ns / 1ps
package ssrrip_pkg;

   localparam int LINE_W = 58;
   localparam int SIG_W  = 6;

   localparam logic [1:0] RRPV_FAR  = 2'd3;
   localparam logic [1:0] RRPV_LONG = 2'd2;
   localparam logic [1:0] RUN_FULL  = 2'd3;

   // commands
   localparam logic CMD_VICTIM = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   // register index (paddr bit 2)
   localparam logic CSR_STREAM_WINDOW = 1'b0;
   localparam logic CSR_LEADER_COUNT  = 1'b1;

   localparam logic [3:0]  STREAM_WIN_RESET = 4'd8;
   localparam logic [10:0] LEADER_RESET     = 11'd64;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_FILL
   } state_type;

   typedef enum logic [1:0] {
      LEAD_NONE,
      LEAD_SRRIP,
      LEAD_BRRIP
   } leader_type;

endpackage

// ===== hdl/stream_aware_ship_rrip_replacement_core.sv =====
// Victim command: accepted in idle, result strobe in the execute state; update: execute only on a hit or an
// ignored request, execute then fill on a fill (extra signature table read). One request at a time;
// start is taken whenever busy is low. The set row memory is read per request and written
// back unless the request is ignored. Reset is synchronous; afterwards busy stays high while
// the set row memory is swept to zero. Signature table entries read as 1 until first written.
`timescale 1ns / 1ps
module stream_aware_ship_rrip_replacement_core
   import ssrrip_pkg::*;
#(
   parameter int NUM_SETS          = 2048,
   parameter int NUM_WAYS          = 16,
   parameter int SELECTOR_BITS     = 10,
   parameter int SIGNATURE_ENTRIES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_command,
   input  logic [10:0]       req_set_index,
   input  logic [3:0]        req_way_index,
   input  logic [LINE_W-1:0] req_line_address,
   input  logic [SIG_W-1:0]  req_pc_signature,
   input  logic              req_hit,
   output logic              rsp_strobe,
   output logic [3:0]        rsp_victim_way,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int SET_W    = $clog2(NUM_SETS);
   localparam int WAY_W    = $clog2(NUM_WAYS);
   localparam int SOT_W    = $clog2(SIGNATURE_ENTRIES);
   localparam int RRPV_LO  = 0;
   localparam int SIG_LO   = 2 * NUM_WAYS;
   localparam int REUSE_LO = 8 * NUM_WAYS;
   localparam int LAST_LO  = 10 * NUM_WAYS;
   localparam int RUN_LO   = LAST_LO + LINE_W;
   localparam int FLAG_LO  = RUN_LO + 2;
   localparam int WIN_LO   = FLAG_LO + 1;
   localparam int ROW_W    = WIN_LO + 4;
   localparam logic [SELECTOR_BITS-1:0] SEL_MAX  = '1;
   localparam logic [SELECTOR_BITS-1:0] SEL_HALF = SEL_MAX >> 1;

   function automatic logic [SOT_W-1:0] sig_mod(input logic [SIG_W-1:0] sig);
      logic [12:0] v;
      v = 13'(sig);
      for (int i = 0; i < 4; i++) begin
         if (v >= 13'(SIGNATURE_ENTRIES)) v = v - 13'(SIGNATURE_ENTRIES);
      end
      return v[SOT_W-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [SET_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [3:0]  win_cfg_ff;
   logic [10:0] lead_cfg_ff;
   logic [SELECTOR_BITS-1:0] psel_ff, psel_in;
   logic [15:0] lfsr_ff, lfsr_in;
   logic [SIGNATURE_ENTRIES-1:0] sot_valid_ff;
   logic sot_vld_ff;
   logic [1:0] sot_idx_ff;

   // captured request
   logic              cmd_ff, hit_ff;
   logic [16:0]       set_ff;
   logic [4:0]        way_ff;
   logic [LINE_W-1:0] line_ff;
   logic [SIG_W-1:0]  sig_ff;

   // memory ports
   logic             row_we, row_re;
   logic [SET_W-1:0] row_wa, row_ra;
   logic [ROW_W-1:0] row_wd, row_q;
   logic             sot_we, sot_re;
   logic [SOT_W-1:0] sot_wa, sot_ra;
   logic [1:0]       sot_wd, sot_q;

   ssrrip_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_row_ram (
      .clock(clock), .wr_en(row_we), .wr_addr(row_wa), .wr_data(row_wd),
      .rd_en(row_re), .rd_addr(row_ra), .rd_data(row_q)
   );

   ssrrip_ram #(.WIDTH(2), .DEPTH(SIGNATURE_ENTRIES)) u_sot_ram (
      .clock(clock), .wr_en(sot_we), .wr_addr(sot_wa), .wr_data(sot_wd),
      .rd_en(sot_re), .rd_addr(sot_ra), .rd_data(sot_q)
   );

   // derived from the captured request and the row read data
   logic             set_ok, way_ok;
   logic [SET_W-1:0] set_a;
   logic [WAY_W-1:0] way_a;
   logic [SOT_W-1:0] idx_a, old_idx;
   logic [1:0]       sot_cur;
   leader_type       kind;
   logic [16:0]      mirror;
   logic             lo_lead, hi_lead;

   assign set_ok  = set_ff < 17'(NUM_SETS);
   assign way_ok  = 6'(way_ff) < 6'(NUM_WAYS);
   assign set_a   = set_ff[SET_W-1:0];
   assign way_a   = way_ff[WAY_W-1:0];
   assign idx_a   = sig_mod(sig_ff);
   assign sot_cur = sot_vld_ff ? sot_q : 2'b01;
   assign mirror  = 17'(NUM_SETS - 1) - set_ff;
   assign lo_lead = set_ff < 17'(lead_cfg_ff);
   assign hi_lead = mirror < 17'(lead_cfg_ff);

   always_comb begin
      if (lo_lead && hi_lead) kind = (set_ff > mirror) ? LEAD_SRRIP : LEAD_BRRIP;
      else if (lo_lead)       kind = LEAD_SRRIP;
      else if (hi_lead)       kind = LEAD_BRRIP;
      else                    kind = LEAD_NONE;
   end

   // victim search: set maximum, then first way that holds it
   logic [1:0]       rmax;
   logic [WAY_W-1:0] pick;
   logic [4:0]       pick5;
   logic [ROW_W-1:0] row_aged;

   always_comb begin
      rmax = 2'd0;
      for (int i = 0; i < NUM_WAYS; i++) rmax[1] = rmax[1] | row_q[RRPV_LO + 2*i + 1];
      for (int i = 0; i < NUM_WAYS; i++) begin
         rmax[0] = rmax[0] | (row_q[RRPV_LO + 2*i] & (row_q[RRPV_LO + 2*i + 1] == rmax[1]));
      end
      pick = '0;
      for (int i = NUM_WAYS - 1; i >= 0; i--) begin
         if (row_q[RRPV_LO + 2*i +: 2] == rmax) pick = WAY_W'(i);
      end
      row_aged = row_q;
      for (int i = 0; i < NUM_WAYS; i++) begin
         row_aged[RRPV_LO + 2*i +: 2] = row_q[RRPV_LO + 2*i +: 2] + (RRPV_FAR - rmax);
      end
   end
   assign pick5 = 5'(pick);

   // streaming detector
   logic [LINE_W-1:0] last_line;
   logic [1:0]        run_old, run_new;
   logic              flag_old, flag_new, stride_ok, stream_fill;
   logic [3:0]        win_old, win_new;

   always_comb begin
      last_line = row_q[LAST_LO +: LINE_W];
      run_old   = row_q[RUN_LO +: 2];
      flag_old  = row_q[FLAG_LO];
      win_old   = row_q[WIN_LO +: 4];
      stride_ok = (last_line != '0) &&
                  (({1'b0, line_ff} == {1'b0, last_line} + 59'd1) ||
                   ({1'b0, last_line} == {1'b0, line_ff} + 59'd1));
      if (stride_ok) begin
         run_new  = (run_old < RUN_FULL) ? run_old + 2'd1 : run_old;
         flag_new = flag_old;
         win_new  = win_old;
         if (run_new == RUN_FULL && !flag_old) begin
            flag_new = 1'b1;
            win_new  = win_cfg_ff;
         end
      end else begin
         run_new  = 2'd0;
         flag_new = 1'b0;
         win_new  = 4'd0;
      end
      if (flag_new && win_new != 4'd0) win_new = win_new - 4'd1;
      stream_fill = flag_new && (win_new != 4'd0);
   end

   // block fields of the addressed way
   logic [1:0]       reuse_w;
   logic [SIG_W-1:0] sig_w;
   logic [ROW_W-1:0] row_upd;

   assign reuse_w = row_q[REUSE_LO + 2*way_a +: 2];
   assign sig_w   = row_q[SIG_LO + SIG_W*way_a +: SIG_W];
   assign old_idx = sig_mod(sig_w);

   always_comb begin
      row_upd = row_q;
      row_upd[LAST_LO +: LINE_W] = line_ff;
      row_upd[RUN_LO +: 2]       = run_new;
      row_upd[FLAG_LO]           = flag_new;
      row_upd[WIN_LO +: 4]       = win_new;
   end

   // fill decision
   logic [1:0] old_new, idx_val, fill_rrpv;
   logic       old_dec;

   always_comb begin
      old_dec = (reuse_w == 2'd0) && (sot_cur != 2'd0);
      old_new = old_dec ? sot_cur - 2'd1 : sot_cur;
      idx_val = (old_idx == idx_a) ? old_new : sot_idx_ff;
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      psel_in    = psel_ff;
      lfsr_in    = lfsr_ff;
      row_we     = 1'b0;
      row_wa     = set_a;
      row_wd     = row_upd;
      row_re     = 1'b0;
      row_ra     = SET_W'(req_set_index);
      sot_we     = 1'b0;
      sot_wa     = idx_a;
      sot_wd     = sot_cur;
      sot_re     = 1'b0;
      sot_ra     = sig_mod(req_pc_signature);
      rsp_strobe = 1'b0;
      rsp_victim_way = 4'd0;
      fill_rrpv  = RRPV_FAR;
      unique case (state_ff)
         ST_CLEAR: begin
            row_we     = 1'b1;
            row_wa     = clr_cnt_ff;
            row_wd     = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == SET_W'(NUM_SETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               row_re   = 1'b1;
               sot_re   = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            if (cmd_ff == CMD_VICTIM) begin
               rsp_strobe = 1'b1;
               if (set_ok) begin
                  rsp_victim_way = pick5[3:0];
                  row_we = 1'b1;
                  row_wd = row_aged;
               end
            end else if (set_ok && way_ok) begin
               if (hit_ff) begin
                  row_we = 1'b1;
                  row_wd[RRPV_LO + 2*way_a +: 2] = 2'd0;
                  row_wd[REUSE_LO + 2*way_a +: 2] =
                     (reuse_w < 2'd3) ? reuse_w + 2'd1 : reuse_w;
                  sot_we = 1'b1;
                  sot_wd = (sot_cur < 2'd3) ? sot_cur + 2'd1 : sot_cur;
               end else begin
                  sot_re   = 1'b1;
                  sot_ra   = old_idx;
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            state_in = ST_IDLE;
            sot_we   = old_dec;
            sot_wa   = old_idx;
            sot_wd   = old_new;
            if (stream_fill) begin
               fill_rrpv = RRPV_FAR;
            end else if (idx_val >= 2'd2) begin
               fill_rrpv = 2'd0;
               if (kind == LEAD_SRRIP && psel_ff < SEL_MAX) psel_in = psel_ff + 1'b1;
               else if (kind == LEAD_BRRIP && psel_ff != '0) psel_in = psel_ff - 1'b1;
            end else if (kind == LEAD_SRRIP ||
                         (kind == LEAD_NONE && psel_ff >= SEL_HALF)) begin
               fill_rrpv = RRPV_LONG;
            end else begin
               // BRRIP coin from the Galois LFSR
               lfsr_in   = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? 16'hB400 : 16'h0000);
               fill_rrpv = lfsr_ff[0] ? RRPV_LONG : RRPV_FAR;
            end
            row_we = 1'b1;
            row_wd[RRPV_LO + 2*way_a +: 2]          = fill_rrpv;
            row_wd[SIG_LO + SIG_W*way_a +: SIG_W]   = sig_ff;
            row_wd[REUSE_LO + 2*way_a +: 2]         = 2'd0;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         psel_ff      <= SEL_HALF;
         lfsr_ff      <= 16'hACE1;
         sot_valid_ff <= '0;
         sot_vld_ff   <= 1'b0;
         win_cfg_ff   <= STREAM_WIN_RESET;
         lead_cfg_ff  <= LEADER_RESET;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         psel_ff    <= psel_in;
         lfsr_ff    <= lfsr_in;
         if (sot_we) sot_valid_ff[sot_wa] <= 1'b1;
         if (sot_re) sot_vld_ff <= sot_valid_ff[sot_ra];
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == CSR_STREAM_WINDOW) win_cfg_ff  <= pwdata[3:0];
            else                               lead_cfg_ff <= pwdata[10:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         cmd_ff  <= req_command;
         set_ff  <= 17'(req_set_index);
         way_ff  <= 5'(req_way_index);
         line_ff <= req_line_address;
         sig_ff  <= req_pc_signature;
         hit_ff  <= req_hit;
      end
      if (state_ff == ST_EXEC) sot_idx_ff <= sot_cur;
   end

   assign pready = 1'b1;
   always_comb begin
      unique case (paddr[2])
         CSR_STREAM_WINDOW: prdata = {28'd0, win_cfg_ff};
         default:           prdata = {21'd0, lead_cfg_ff};
      endcase
   end

   a_strobe_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == ST_EXEC && cmd_ff == CMD_VICTIM))
      else $error("result strobe outside a victim request");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && state_ff == ST_EXEC))
      else $error("accepted request did not start");
   a_fill_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> ($past(state_ff) == ST_EXEC && !hit_ff))
      else $error("fill step without preceding miss update");
   a_no_strobe_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!rsp_strobe && row_we))
      else $error("clearing sweep disturbed");

endmodule

// ===== hdl/ssrrip_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ssrrip_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== tb/sv/tb_ssrrip_checker.sv =====
// Checker for the stream-aware SHiP/DRRIP replacement core: watches the request, response
// and APB ports, predicts victim ways and compares them. Depends on ssrrip_pkg.
`timescale 1ns / 1ps
module tb_ssrrip_checker
   import ssrrip_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic              req_command,
   input  logic [10:0]       req_set_index,
   input  logic [3:0]        req_way_index,
   input  logic [LINE_W-1:0] req_line_address,
   input  logic [SIG_W-1:0]  req_pc_signature,
   input  logic              req_hit,
   input  logic              rsp_strobe,
   input  logic [3:0]        rsp_victim_way,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   input  logic              pready,
   output int                fail_count,
   output int                pending
);
   localparam int SETS = 2048;
   localparam int WAYS = 16;
   localparam logic [9:0] SEL_TOP = 10'd1023;
   localparam logic [9:0] SEL_MID = 10'd511;

   logic [1:0]        rrpv_mem   [0:SETS*WAYS-1];
   logic [5:0]        sig_mem    [0:SETS*WAYS-1];
   logic [1:0]        reuse_mem  [0:SETS*WAYS-1];
   logic [1:0]        outcome_tbl[0:63];
   logic [LINE_W-1:0] prev_line  [0:SETS-1];
   logic [1:0]        run_len    [0:SETS-1];
   logic              streaming  [0:SETS-1];
   logic [3:0]        window_cnt [0:SETS-1];
   logic [9:0]        duel_sel;
   logic [15:0]       coin_lfsr;
   logic [3:0]        win_len;
   logic [10:0]       lead_cnt;
   logic [3:0]        victim_q[$];

   function automatic leader_type leader_of(input logic [10:0] s);
      logic [10:0] mirror;
      logic        lo, hi;
      mirror = 11'(SETS - 1) - s;
      lo = s < lead_cnt;
      hi = mirror < lead_cnt;
      if (lo && hi) return (s > mirror) ? LEAD_SRRIP : LEAD_BRRIP;
      if (lo) return LEAD_SRRIP;
      if (hi) return LEAD_BRRIP;
      return LEAD_NONE;
   endfunction

   task automatic clear_model();
      for (int i = 0; i < SETS*WAYS; i++) begin
         rrpv_mem[i] = '0; sig_mem[i] = '0; reuse_mem[i] = '0;
      end
      for (int i = 0; i < 64; i++) outcome_tbl[i] = 2'd1;
      for (int i = 0; i < SETS; i++) begin
         prev_line[i] = '0; run_len[i] = '0; streaming[i] = 1'b0; window_cnt[i] = '0;
      end
      duel_sel  = SEL_MID;
      coin_lfsr = 16'hACE1;
      win_len   = STREAM_WIN_RESET;
      lead_cnt  = LEADER_RESET;
      victim_q.delete();
   endtask

   task automatic predict_access(input logic cmd, input logic [10:0] s, input logic [3:0] w,
                                 input logic [LINE_W-1:0] line, input logic [5:0] sig,
                                 input logic hit);
      int          base, b;
      logic [1:0]  top, old_sig_val;
      logic [3:0]  pick;
      logic        found, fill_stream, srrip, coin;
      logic [LINE_W:0] l1, p1;
      leader_type  kind;
      base = int'(s) * WAYS;
      if (cmd == CMD_VICTIM) begin
         top = '0;
         for (int i = 0; i < WAYS; i++) if (rrpv_mem[base+i] > top) top = rrpv_mem[base+i];
         for (int i = 0; i < WAYS; i++) rrpv_mem[base+i] = rrpv_mem[base+i] + (RRPV_FAR - top);
         pick = '0; found = 1'b0;
         for (int i = 0; i < WAYS; i++)
            if (!found && rrpv_mem[base+i] == RRPV_FAR) begin
               pick = 4'(i); found = 1'b1;
            end
         victim_q.push_back(pick);
         return;
      end
      b = base + int'(w);
      kind = leader_of(s);
      l1 = {1'b0, line};
      p1 = {1'b0, prev_line[s]};
      if (prev_line[s] != 0 && (l1 == p1 + 1 || p1 == l1 + 1)) begin
         if (run_len[s] < RUN_FULL) run_len[s]++;
         if (run_len[s] == RUN_FULL && !streaming[s]) begin
            streaming[s] = 1'b1;
            window_cnt[s] = win_len;
         end
      end else begin
         run_len[s] = '0; streaming[s] = 1'b0; window_cnt[s] = '0;
      end
      prev_line[s] = line;
      if (streaming[s] && window_cnt[s] > 0) window_cnt[s]--;
      fill_stream = streaming[s] && window_cnt[s] > 0;
      if (hit) begin
         rrpv_mem[b] = '0;
         if (reuse_mem[b] < 3) reuse_mem[b]++;
         if (outcome_tbl[sig] < 3) outcome_tbl[sig]++;
         return;
      end
      old_sig_val = outcome_tbl[sig_mem[b]];
      if (reuse_mem[b] == 0 && old_sig_val > 0) outcome_tbl[sig_mem[b]] = old_sig_val - 2'd1;
      sig_mem[b] = sig;
      reuse_mem[b] = '0;
      if (fill_stream) rrpv_mem[b] = RRPV_FAR;
      else if (outcome_tbl[sig] >= 2) rrpv_mem[b] = '0;
      else begin
         if (kind == LEAD_SRRIP) srrip = 1'b1;
         else if (kind == LEAD_BRRIP) srrip = 1'b0;
         else srrip = duel_sel >= SEL_MID;
         if (srrip) rrpv_mem[b] = RRPV_LONG;
         else begin
            coin = coin_lfsr[0];
            coin_lfsr = coin_lfsr >> 1;
            if (coin) coin_lfsr ^= 16'hB400;
            rrpv_mem[b] = coin ? RRPV_LONG : RRPV_FAR;
         end
      end
      if (rrpv_mem[b] == 0) begin
         if (kind == LEAD_SRRIP && duel_sel < SEL_TOP) duel_sel++;
         else if (kind == LEAD_BRRIP && duel_sel > 0) duel_sel--;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_model();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (victim_q.size() == 0) begin
               $error("victim_way: unexpected response %0d", rsp_victim_way);
               fail_count++;
            end else begin
               if (rsp_victim_way !== victim_q[0]) begin
                  $error("victim_way: expected %0d, actual %0d", victim_q[0], rsp_victim_way);
                  fail_count++;
               end
               void'(victim_q.pop_front());
            end
         end
         if (start && !busy)
            predict_access(req_command, req_set_index, req_way_index, req_line_address,
                           req_pc_signature, req_hit);
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == CSR_STREAM_WINDOW) win_len = pwdata[3:0];
            else lead_cnt = pwdata[10:0];
         end
      end
      pending = victim_q.size();
   end
endmodule

// ===== tb/sv/tb_stream_aware_ship_rrip_replacement_core.sv =====
// Testbench top: directed and random victim/update requests with streaming runs,
// APB register phases and random start gaps. Depends on ssrrip_pkg, tb_ssrrip_checker and the core.
`timescale 1ns / 1ps
module tb_stream_aware_ship_rrip_replacement_core
   import ssrrip_pkg::*;
;

   logic              clock, reset, start, busy;
   logic              req_command, req_hit;
   logic [10:0]       req_set_index;
   logic [3:0]        req_way_index;
   logic [LINE_W-1:0] req_line_address;
   logic [SIG_W-1:0]  req_pc_signature;
   logic              rsp_strobe;
   logic [3:0]        rsp_victim_way;
   logic              psel, penable, pwrite, pready;
   logic [2:0]        paddr;
   logic [31:0]       pwdata, prdata;
   int                fail_count, pending;
   logic              gaps_on;

   localparam logic [10:0] HOT_SETS [16] = '{11'd0, 11'd1, 11'd2, 11'd62, 11'd63, 11'd64,
      11'd65, 11'd500, 11'd1000, 11'd1023, 11'd1024, 11'd1500, 11'd1983, 11'd1984,
      11'd2046, 11'd2047};

   stream_aware_ship_rrip_replacement_core u_top (.*);

   tb_ssrrip_checker u_checker (.*);

   always #10 clock = ~clock;

   task automatic issue(input logic cmd, input logic [10:0] s, input logic [3:0] w,
                        input logic [LINE_W-1:0] line, input logic [5:0] sig,
                        input logic hit);
      logic taken;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd; req_set_index <= s; req_way_index <= w;
      req_line_address <= line; req_pc_signature <= sig; req_hit <= hit;
      do begin
         @(negedge clock) taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic csr_write(input logic reg_sel, input logic [31:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {reg_sel, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   // quiesce: no victim answers outstanding and any update finished
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [LINE_W-1:0] rand_line();
      return LINE_W'({$urandom(), $urandom()});
   endfunction

   task automatic random_phase(input int n_items);
      int               done, len;
      logic [10:0]      s;
      logic [LINE_W-1:0] line;
      logic [5:0]       sig;
      logic             down;
      done = 0;
      while (done < n_items) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               // stride run on one set, mixed with victim lookups
               s = HOT_SETS[$urandom_range(0, 15)];
               line = ($urandom_range(0, 7) == 0) ? LINE_W'($urandom_range(1, 6)) : rand_line();
               down = 1'($urandom_range(0, 1));
               sig = 6'($urandom_range(0, 7));
               len = $urandom_range(2, 10);
               for (int i = 0; i < len; i++) begin
                  if ($urandom_range(0, 3) == 0) begin
                     issue(CMD_VICTIM, s, 4'($urandom), rand_line(), 6'($urandom), 1'($urandom));
                     done++;
                  end
                  issue(CMD_UPDATE, s, 4'($urandom), line, sig, $urandom_range(0, 9) < 3);
                  done++;
                  line = down ? line - 1 : line + 1;
                  if ($urandom_range(0, 15) == 0) line = rand_line();
               end
            end
            6, 7: begin
               s = HOT_SETS[$urandom_range(0, 15)];
               issue(1'($urandom_range(0, 1)), s, 4'($urandom), rand_line(),
                     6'($urandom_range(0, 7)), 1'($urandom));
               done++;
            end
            default: begin
               issue(1'($urandom), 11'($urandom), 4'($urandom), rand_line(), 6'($urandom),
                     1'($urandom));
               done++;
            end
         endcase
      end
   endtask

   initial begin
      clock = 0; reset = 1; start = 0; gaps_on = 0;
      req_command = 0; req_set_index = 0; req_way_index = 0;
      req_line_address = 0; req_pc_signature = 0; req_hit = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock); while (busy);
      @(posedge clock);

      // directed: field extremes, stride up and down, hits, leader sets
      issue(CMD_VICTIM, 11'd0, 4'd0, '0, 6'd0, 1'b0);
      issue(CMD_UPDATE, 11'd0, 4'd0, '1, 6'd0, 1'b0);
      issue(CMD_UPDATE, 11'd0, 4'd15, '0, 6'd63, 1'b1);
      issue(CMD_VICTIM, 11'd0, 4'd15, '1, 6'd63, 1'b1);
      for (int i = 0; i < 5; i++)
         issue(CMD_UPDATE, 11'd100, 4'(i), LINE_W'(10 + i), 6'd5, 1'b0);
      issue(CMD_VICTIM, 11'd100, 4'd0, '0, 6'd0, 1'b0);
      for (int i = 0; i < 4; i++)
         issue(CMD_UPDATE, 11'd101, 4'(i), LINE_W'(20 - i), 6'd9, 1'b0);
      issue(CMD_VICTIM, 11'd101, 4'd0, '0, 6'd0, 1'b0);
      issue(CMD_UPDATE, 11'd2047, 4'd15, '1, 6'd63, 1'b1);
      issue(CMD_UPDATE, 11'd2047, 4'd3, 58'h2AAAAAAAAAAAAAA, 6'd2, 1'b0);
      issue(CMD_VICTIM, 11'd2047, 4'd0, '0, 6'd0, 1'b0);
      drain();

      gaps_on = 1;
      random_phase(250);
      drain();
      csr_write(CSR_STREAM_WINDOW, 32'd0);
      csr_write(CSR_LEADER_COUNT, 32'd0);
      random_phase(250);
      drain();
      csr_write(CSR_STREAM_WINDOW, 32'hFFFF_FFFF);
      csr_write(CSR_LEADER_COUNT, 32'd1024);
      random_phase(250);
      drain();
      csr_write(CSR_STREAM_WINDOW, 32'd3);
      csr_write(CSR_LEADER_COUNT, 32'd2047);
      random_phase(250);
      drain();
      csr_write(CSR_STREAM_WINDOW, 32'd1);
      csr_write(CSR_LEADER_COUNT, 32'd1500);
      gaps_on = 0;
      random_phase(230);
      drain();

      if (fail_count == 0) $display("PASS stream_aware_ship_rrip_replacement_core");
      else $display("FAIL stream_aware_ship_rrip_replacement_core");
      $finish;
   end

   initial begin
      #10ms;
      $display("FAIL stream_aware_ship_rrip_replacement_core");
      $finish;
   end
endmodule
